>>> hdl/fac_pkg.sv
// Shared types and constants for the frame autocorrelation block.
// No dependencies; every other file imports this package.
`default_nettype none

package fac_pkg;

    localparam int CFG_BITS = 5;
    localparam logic [CFG_BITS-1:0] LAG_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_DRAIN
    } fac_state_t;

    typedef struct packed {
        logic shift;
        logic clear_taps;
        logic acc_en;
        logic drain;
        logic clear_acc;
    } fac_cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/fac_if.sv
// Channel interfaces of the frame autocorrelation block: samples, results, config.
// Depends on fac_pkg for the config width.
`default_nettype none

interface fac_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;

    modport source (output valid, sample, frame_end, input ready);
    modport sink   (input valid, sample, frame_end, output ready);
endinterface

interface fac_result_if #(
    parameter int SUM_BITS = 48,
    parameter int IDX_BITS = 4
);
    logic                       valid;
    logic                       ready;
    logic signed [SUM_BITS-1:0] lag_value;
    logic [IDX_BITS-1:0]        lag_index;
    logic                       last_lag;

    modport source (output valid, lag_value, lag_index, last_lag, input ready);
    modport sink   (input valid, lag_value, lag_index, last_lag, output ready);
endinterface

interface fac_cfg_if
    import fac_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hdl/fac_cell.sv
// One lag cell: delay tap, product register and saturating accumulator.
// Depends on fac_pkg for the cell control struct.
`default_nettype none

module fac_cell
    import fac_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fac_cell_ctl_t                 ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] x,
    input  wire logic signed [SAMPLE_BITS-1:0] tap_in,
    output logic signed [SAMPLE_BITS-1:0]      tap_out,
    input  wire logic signed [SUM_BITS-1:0]    acc_right,
    output logic signed [SUM_BITS-1:0]         acc_out
);

    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam int WIDE_BITS = ((PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS) + 1;

    localparam logic signed [WIDE_BITS-1:0] SUM_HI =
        WIDE_BITS'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_BITS-1:0] SUM_LO = -SUM_HI - WIDE_BITS'(1);

    logic signed [SAMPLE_BITS-1:0] tap_reg, tap_next;
    logic signed [PROD_BITS-1:0]   prod_reg, prod_next;
    logic signed [SUM_BITS-1:0]    acc_reg, acc_next;
    logic signed [WIDE_BITS-1:0]   wide_sum;
    logic signed [SUM_BITS-1:0]    sat_sum;

    always_comb
    begin
        wide_sum = WIDE_BITS'(acc_reg) + WIDE_BITS'(prod_reg);
        if (wide_sum > SUM_HI)
        begin
            sat_sum = SUM_BITS'(SUM_HI);
        end
        else if (wide_sum < SUM_LO)
        begin
            sat_sum = SUM_BITS'(SUM_LO);
        end
        else
        begin
            sat_sum = SUM_BITS'(wide_sum);
        end
    end

    always_comb
    begin
        tap_next  = tap_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (ctl.shift)
        begin
            prod_next = PROD_BITS'(x) * PROD_BITS'(tap_in);
            tap_next  = tap_in;
        end
        if (ctl.clear_taps)
        begin
            tap_next = '0;
        end
        if (ctl.clear_acc)
        begin
            acc_next = '0;
        end
        else if (ctl.drain)
        begin
            acc_next = acc_right;
        end
        else if (ctl.acc_en)
        begin
            acc_next = sat_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            tap_reg <= tap_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign tap_out = tap_reg;
    assign acc_out = acc_reg;

endmodule

`default_nettype wire

>>> hdl/fac_ctrl.sv
// Frame sequencer: sample intake, flush of the last product, result drain.
// Depends on fac_pkg for the state type and the cell control struct.
`default_nettype none

module fac_ctrl
    import fac_pkg::*;
#(
    parameter int MAX_LAGS = 16,
    parameter int IDX_BITS = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_frame_end,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [IDX_BITS-1:0]      out_index,
    output logic                     out_last,
    input  wire logic [CFG_BITS-1:0] lag_count,
    output fac_cell_ctl_t            ctl
);

    localparam int MAXL_BITS = $clog2(MAX_LAGS + 1);
    localparam int CW = (MAXL_BITS > CFG_BITS) ? MAXL_BITS : CFG_BITS;
    localparam logic [CW-1:0] MAXL = CW'(MAX_LAGS);

    fac_state_t          state_reg, state_next;
    logic                pvalid_reg, pvalid_next;
    logic [IDX_BITS-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]       lc_ext;
    logic [CW-1:0]       eff_m1;
    logic                in_beat;
    logic                out_beat;

    always_comb
    begin
        lc_ext = CW'(lag_count);
        if (lc_ext == '0)
        begin
            eff_m1 = '0;
        end
        else if (lc_ext > MAXL)
        begin
            eff_m1 = MAXL - CW'(1);
        end
        else
        begin
            eff_m1 = lc_ext - CW'(1);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        out_last    = (CW'(cnt_reg) == eff_m1);
        case (state_reg)
            ST_RUN:
            begin
                in_ready = 1'b1;
                if (in_valid && in_frame_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DRAIN;
                cnt_next   = '0;
            end
            ST_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (out_last)
                    begin
                        state_next = ST_RUN;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IDX_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        in_beat        = in_ready && in_valid;
        out_beat       = out_valid && out_ready;
        pvalid_next    = in_beat;
        ctl.shift      = in_beat;
        ctl.clear_taps = in_beat && in_frame_end;
        ctl.acc_en     = pvalid_reg;
        ctl.drain      = out_beat && !out_last;
        ctl.clear_acc  = out_beat && out_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RUN;
            pvalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pvalid_reg <= pvalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign out_index = cnt_reg;

endmodule

`default_nettype wire

>>> hdl/frame_autocorrelation.sv
// Top level of the frame autocorrelation block: config register, sequencer, lag cells.
// Depends on fac_pkg, fac_if, fac_cell and fac_ctrl.
//
//  channel  | dir | payload                          | beat
//  ---------+-----+----------------------------------+-------------------------
//  samples  | in  | sample, frame_end                | valid && ready
//  results  | out | lag_value, lag_index, last_lag   | valid && ready
//  cfg      | in  | data (lag_count)                 | valid && ready, ready = 1
//
// Samples are taken one per cycle in the run state; every lag cell multiplies and accumulates in parallel.
// After a frame-end beat the last product is registered, then added in the flush state, before results.
// Results then drain one lag per cycle while output ready is high, shifting accumulators toward cell zero.
// Input ready is low from frame-end beat until the final result beat; output stalls hold.
// Reset clears taps and accumulators and sets lag_count to 16; no clearing pass is needed.
`default_nettype none

module frame_autocorrelation
    import fac_pkg::*;
#(
    parameter int MAX_LAGS    = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 48
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fac_sample_if.sink  samples,
    fac_result_if.source results,
    fac_cfg_if.sink     cfg
);

    localparam int IDX_BITS = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;

    logic [CFG_BITS-1:0]           lag_count_reg, lag_count_next;
    fac_cell_ctl_t                 ctl;
    logic signed [SAMPLE_BITS-1:0] taps [MAX_LAGS+1];
    logic signed [SUM_BITS-1:0]    accs [MAX_LAGS+1];

    assign cfg.ready = 1'b1;

    always_comb
    begin
        lag_count_next = lag_count_reg;
        if (cfg.valid)
        begin
            lag_count_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_count_reg <= LAG_COUNT_RESET;
        end
        else
        begin
            lag_count_reg <= lag_count_next;
        end
    end

    fac_ctrl #(
        .MAX_LAGS (MAX_LAGS),
        .IDX_BITS (IDX_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (samples.valid),
        .in_frame_end (samples.frame_end),
        .in_ready     (samples.ready),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .out_index    (results.lag_index),
        .out_last     (results.last_lag),
        .lag_count    (lag_count_reg),
        .ctl          (ctl)
    );

    assign taps[0]        = samples.sample;
    assign accs[MAX_LAGS] = '0;

    for (genvar j = 0; j < MAX_LAGS; j++)
    begin : g_cell
        fac_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .SUM_BITS    (SUM_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .x         (samples.sample),
            .tap_in    (taps[j]),
            .tap_out   (taps[j+1]),
            .acc_right (accs[j+1]),
            .acc_out   (accs[j])
        );
    end

    assign results.lag_value = accs[0];

endmodule

`default_nettype wire
